// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of the scheduler.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/pps_pkg.sv -----
// Shared types and constants of the preemptive priority scheduler.
// Used by the cell, the top level, the checker and the bench; depends on nothing.
package pps_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic [2:0] EV_ACCEPT = 3'd0;
  localparam logic [2:0] EV_FULL   = 3'd1;
  localparam logic [2:0] EV_IDLE   = 3'd2;
  localparam logic [2:0] EV_WORKED = 3'd3;
  localparam logic [2:0] EV_DONE   = 3'd4;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] work;
    logic [7:0]  prio;
    logic [31:0] arrival;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
    logic dec;
  } cell_ctl_t;

endpackage

// ----- sv/pps_cell.sv -----
// One slot of the sorted job chain: holds a job and trades it with its neighbors.
// Depends on pps_pkg for the entry and control types.
module pps_cell (
  input  logic               clk,
  input  pps_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               left_keep,
  input  pps_pkg::entry_t    new_entry,
  input  pps_pkg::entry_t    left_entry,
  input  pps_pkg::entry_t    right_entry,
  output logic               keep,
  output pps_pkg::entry_t    entry
);

  // An occupied slot of equal or higher priority stays ahead of the arrival.
  assign keep = occupied && (entry.prio >= new_entry.prio);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (!keep) begin
        // The first slot that gives way takes the arrival; the rest shift right.
        if (left_keep) begin
          entry <= new_entry;
        end else begin
          entry <= left_entry;
        end
      end
    end else if (ctl.pop) begin
      entry <= right_entry;
    end else if (ctl.dec) begin
      entry.work <= entry.work - 16'd1;
    end
  end

endmodule

// ----- sv/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler: a chain of pps_cell slots kept in priority order.
// Depends on pps_pkg and pps_cell.
//
// Each transfer, arrival or tick, is worked in the cycle it is taken, and its result
// stands in the output register from the next cycle, so one item per cycle is
// sustained. All slots of the chain update together: an arrival slides into its
// place while the lower entries shift one slot down, and a finished head job leaves
// while the rest shift up. The input stalls only while a result waits on a stalled
// output. An arrival into a full table is reported as rejected and changes nothing.
module preemptive_priority_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [15:0] job_id,
  input  logic [15:0] work_needed,
  input  logic [7:0]  job_priority,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_code,
  output logic [15:0] served_id,
  output logic [15:0] work_left,
  output logic [31:0] turnaround,
  output logic [31:0] current_tick
);

  localparam int unsigned Depth = pps_pkg::QUEUE_DEPTH;
  localparam int unsigned OccW  = pps_pkg::OCC_W;

  logic [OccW-1:0]    occupancy;
  logic [31:0]        tick_count;
  logic               take;
  logic               full;
  logic               head_done;
  logic [15:0]        head_left;
  pps_pkg::entry_t    new_entry;
  pps_pkg::entry_t    entries [Depth];
  logic               keeps [Depth];
  pps_pkg::cell_ctl_t ctl;

  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;
  assign full     = occupancy == OccW'(Depth);

  assign head_left = entries[0].work - 16'd1;
  assign head_done = head_left == 16'd0;

  always_comb begin
    new_entry.id      = job_id;
    new_entry.work    = (work_needed == 16'd0) ? 16'd1 : work_needed;
    new_entry.prio    = job_priority;
    new_entry.arrival = tick_count;
  end

  always_comb begin
    ctl.insert = take && (req_type == pps_pkg::REQ_ARRIVAL) && !full;
    ctl.pop    = take && (req_type == pps_pkg::REQ_TICK) && (occupancy != '0) && head_done;
    ctl.dec    = take && (req_type == pps_pkg::REQ_TICK) && (occupancy != '0) && !head_done;
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    pps_pkg::cell_ctl_t cctl;
    pps_pkg::entry_t    left_e;
    pps_pkg::entry_t    right_e;
    logic               lkeep;

    always_comb begin
      cctl.insert = ctl.insert;
      cctl.pop    = ctl.pop;
      cctl.dec    = (i == 0) ? ctl.dec : 1'b0;
    end

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign lkeep  = 1'b1;
    end else begin : g_mid
      assign left_e = entries[i-1];
      assign lkeep  = keeps[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    pps_cell u_cell (
      .clk        (clk),
      .ctl        (cctl),
      .occupied   (OccW'(i) < occupancy),
      .left_keep  (lkeep),
      .new_entry  (new_entry),
      .left_entry (left_e),
      .right_entry(right_e),
      .keep       (keeps[i]),
      .entry      (entries[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy  <= '0;
      tick_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctl.insert) begin
        occupancy <= occupancy + OccW'(1);
      end else if (ctl.pop) begin
        occupancy <= occupancy - OccW'(1);
      end
      if (take && (req_type == pps_pkg::REQ_TICK)) begin
        tick_count <= tick_count + 32'd1;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; loaded only on an input transfer so a stalled result holds.
  always_ff @(posedge clk) begin
    if (take) begin
      current_tick <= tick_count;
      turnaround   <= 32'd0;
      if (req_type == pps_pkg::REQ_ARRIVAL) begin
        served_id <= job_id;
        if (full) begin
          event_code <= pps_pkg::EV_FULL;
          work_left  <= 16'd0;
        end else begin
          event_code <= pps_pkg::EV_ACCEPT;
          work_left  <= new_entry.work;
        end
      end else if (occupancy == '0) begin
        event_code <= pps_pkg::EV_IDLE;
        served_id  <= 16'd0;
        work_left  <= 16'd0;
      end else begin
        served_id <= entries[0].id;
        work_left <= head_left;
        if (head_done) begin
          event_code <= pps_pkg::EV_DONE;
          turnaround <= tick_count - entries[0].arrival + 32'd1;
        end else begin
          event_code <= pps_pkg::EV_WORKED;
        end
      end
    end
  end

endmodule

// ----- sv/pps_checker.sv -----
// Port-level checks of the preemptive priority scheduler, bound to its top level.
// Depends on assert_macros.svh and pps_pkg for the event codes.
`include "assert_macros.svh"

module pps_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  event_code,
  input logic [15:0] served_id,
  input logic [15:0] work_left,
  input logic [31:0] turnaround
);

  logic idle_clean;
  logic worked_clean;

  assign idle_clean   = (served_id == 16'd0) && (work_left == 16'd0) && (turnaround == 32'd0);
  assign worked_clean = (work_left != 16'd0) && (turnaround == 32'd0);

  // A result that is not taken stays on offer.
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // The input only stalls behind a result that waits.
  `ASSERT_IMPL(a_stall_cause, in_stall, out_valid)

  // An idle tick concerns no job.
  `ASSERT_IMPL(a_idle_empty, out_valid && (event_code == pps_pkg::EV_IDLE), idle_clean)

  // A completion leaves no work, and a worked tick always leaves some.
  `ASSERT_IMPL(a_done_zero, out_valid && (event_code == pps_pkg::EV_DONE), work_left == 16'd0)
  `ASSERT_IMPL(a_worked_left, out_valid && (event_code == pps_pkg::EV_WORKED), worked_clean)

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

// ----- bench/testbench.sv -----
// Self-checking bench for the preemptive priority scheduler.
// Depends on pps_pkg and the preemptive_priority_scheduler top level only.
// A directed table runs first, then random arrivals and ticks under random idling.
module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic        req;
    logic [15:0] id;
    logic [15:0] work;
    logic [7:0]  prio;
  } job_req_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [15:0] id;
    logic [15:0] left;
    logic [31:0] turn;
    logic [31:0] tick;
  } sched_result_t;

  typedef struct packed {
    job_req_t      item;
    logic          typed;
    sched_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [15:0] job_id;
  logic [15:0] work_needed;
  logic [7:0]  job_priority;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  event_code;
  logic [15:0] served_id;
  logic [15:0] work_left;
  logic [31:0] turnaround;
  logic [31:0] current_tick;

  // Typed expectation that travels with the payload of a directed transfer.
  logic          row_typed;
  sched_result_t row_want;

  // Predictor copy of the job table.
  logic [15:0] job_ids      [pps_pkg::QUEUE_DEPTH];
  logic [15:0] job_work     [pps_pkg::QUEUE_DEPTH];
  logic [7:0]  job_prios    [pps_pkg::QUEUE_DEPTH];
  logic [31:0] job_arrivals [pps_pkg::QUEUE_DEPTH];
  int          jobs_waiting;
  logic [31:0] tick_now;

  sched_result_t expected_events[$];
  int          mismatches;
  int          items_sent;
  int          burst_left;
  int unsigned cycles;

  preemptive_priority_scheduler u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .job_id       (job_id),
    .work_needed  (work_needed),
    .job_priority (job_priority),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_code   (event_code),
    .served_id    (served_id),
    .work_left    (work_left),
    .turnaround   (turnaround),
    .current_tick (current_tick)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  function automatic sched_result_t schedule_event(input job_req_t t);
    sched_result_t r;
    int pos;
    logic [15:0] w;
    r = '0;
    r.tick = tick_now;
    if (t.req == pps_pkg::REQ_ARRIVAL) begin
      r.id = t.id;
      if (jobs_waiting >= pps_pkg::QUEUE_DEPTH) begin
        r.ev = pps_pkg::EV_FULL;
      end else begin
        w = (t.work == 16'd0) ? 16'd1 : t.work;
        pos = 0;
        // Equal priorities keep arrival order: insert before the first strictly lower one.
        while (pos < jobs_waiting && job_prios[pos] >= t.prio) pos++;
        for (int i = jobs_waiting; i > pos; i--) begin
          job_ids[i]      = job_ids[i-1];
          job_work[i]     = job_work[i-1];
          job_prios[i]    = job_prios[i-1];
          job_arrivals[i] = job_arrivals[i-1];
        end
        job_ids[pos]      = t.id;
        job_work[pos]     = w;
        job_prios[pos]    = t.prio;
        job_arrivals[pos] = tick_now;
        jobs_waiting++;
        r.ev   = pps_pkg::EV_ACCEPT;
        r.left = w;
      end
    end else begin
      if (jobs_waiting == 0) begin
        r.ev = pps_pkg::EV_IDLE;
      end else begin
        if (job_work[0] != 16'd0) job_work[0] = job_work[0] - 16'd1;
        r.id = job_ids[0];
        if (job_work[0] == 16'd0) begin
          r.ev   = pps_pkg::EV_DONE;
          r.turn = tick_now - job_arrivals[0] + 32'd1;
          for (int i = 1; i < jobs_waiting; i++) begin
            job_ids[i-1]      = job_ids[i];
            job_work[i-1]     = job_work[i];
            job_prios[i-1]    = job_prios[i];
            job_arrivals[i-1] = job_arrivals[i];
          end
          jobs_waiting--;
        end else begin
          r.ev   = pps_pkg::EV_WORKED;
          r.left = job_work[0];
        end
      end
      tick_now = tick_now + 32'd1;
    end
    return r;
  endfunction

  function automatic string show_result(input sched_result_t r);
    return $sformatf("ev=%0d id=%h left=%h turn=%h tick=%h",
                     r.ev, r.id, r.left, r.turn, r.tick);
  endfunction

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    sched_result_t pred;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {event_code, served_id, work_left, turnaround, current_tick};
        if (expected_events.size() == 0) begin
          note_error({"unexpected result: ", show_result(got)});
        end else begin
          want = expected_events.pop_front();
          if (got !== want)
            note_error({"mismatch: got ", show_result(got), ", expected ", show_result(want)});
        end
      end
      if (in_valid && !in_stall) begin
        pred = schedule_event({req_type, job_id, work_needed, job_priority});
        expected_events.push_back(row_typed ? row_want : pred);
      end
    end
  end

  // Offers one transfer and holds it until the block takes it.
  task automatic send_item(input job_req_t t, input logic typed, input sched_result_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    req_type     <= t.req;
    job_id       <= t.id;
    work_needed  <= t.work;
    job_priority <= t.prio;
    row_typed    <= typed;
    row_want     <= want;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  function automatic dir_row_t dir_row(input logic req, input logic [15:0] id,
                                       input logic [15:0] work, input logic [7:0] prio,
                                       input logic typed, input logic [2:0] ev,
                                       input logic [15:0] sid, input logic [15:0] left,
                                       input logic [31:0] turn, input logic [31:0] tick);
    dir_row_t r;
    r.item.req  = req;
    r.item.id   = id;
    r.item.work = work;
    r.item.prio = prio;
    r.typed     = typed;
    r.want.ev   = ev;
    r.want.id   = sid;
    r.want.left = left;
    r.want.turn = turn;
    r.want.tick = tick;
    return r;
  endfunction

  function automatic job_req_t random_item(input int arrival_pct);
    job_req_t t;
    int roll;
    t.req  = ($urandom_range(0, 99) < arrival_pct) ? pps_pkg::REQ_ARRIVAL : pps_pkg::REQ_TICK;
    t.id   = 16'($urandom_range(0, 65535));
    t.work = 16'($urandom_range(1, 8));
    t.prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 4))
                                         : 8'($urandom_range(1, 255));
    roll = $urandom_range(0, 999);
    if (roll < 20) begin
      t.work = 16'd0;
    end else if (roll < 25) begin
      // Long jobs sit at the lowest priority so they only hold back each other.
      t.work = 16'($urandom_range(1, 65535));
      t.prio = 8'd0;
    end else if (roll < 125) begin
      t.work = 16'($urandom_range(1, 64));
    end
    return t;
  endfunction

  // Receiver: stall patterns that change per stretch, with one long hold-off.
  initial begin
    int seg;
    int mode;
    int period;
    logic held;
    logic s;
    held = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (!held && items_sent >= 300) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      seg    = $urandom_range(20, 200);
      mode   = $urandom_range(0, 3);
      period = $urandom_range(1, 8);
      for (int c = 0; c < seg; c++) begin
        case (mode)
          0: s = 1'b0;
          1: s = ($urandom_range(0, 3) == 0);
          2: s = ($urandom_range(0, 3) != 0);
          default: s = ((c / period) % 2) == 1;
        endcase
        out_stall <= s;
        @(negedge clk);
      end
    end
  end

  initial begin
    dir_row_t directed_rows[$];
    job_req_t t;
    int seg_left;
    int arrival_pct;
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = pps_pkg::REQ_ARRIVAL;
    job_id       = '0;
    work_needed  = '0;
    job_priority = '0;
    out_stall    = 1'b0;
    row_typed    = 1'b0;
    row_want     = '0;
    jobs_waiting = 0;
    tick_now     = '0;
    mismatches   = 0;
    items_sent   = 0;
    burst_left   = 0;
    for (int i = 0; i < pps_pkg::QUEUE_DEPTH; i++) begin
      job_ids[i]      = '0;
      job_work[i]     = '0;
      job_prios[i]    = '0;
      job_arrivals[i] = '0;
    end

    directed_rows.push_back(dir_row(pps_pkg::REQ_TICK, 16'h0000, 16'h0000, 8'h00,
                                    1'b1, pps_pkg::EV_IDLE, 16'h0000, 16'h0000, 32'd0, 32'd0));
    directed_rows.push_back(dir_row(pps_pkg::REQ_ARRIVAL, 16'h0000, 16'h0001, 8'h00,
                                    1'b1, pps_pkg::EV_ACCEPT, 16'h0000, 16'h0001, 32'd0, 32'd1));
    directed_rows.push_back(dir_row(pps_pkg::REQ_TICK, 16'h0000, 16'h0000, 8'h00,
                                    1'b1, pps_pkg::EV_DONE, 16'h0000, 16'h0000, 32'd1, 32'd1));
    directed_rows.push_back(dir_row(pps_pkg::REQ_ARRIVAL, 16'h0010, 16'h0003, 8'h10,
                                    1'b0, pps_pkg::EV_ACCEPT, '0, '0, '0, '0));
    directed_rows.push_back(dir_row(pps_pkg::REQ_TICK, 16'h0000, 16'h0000, 8'h00,
                                    1'b0, pps_pkg::EV_ACCEPT, '0, '0, '0, '0));
    // A top-priority arrival takes over the head from a job already in service.
    directed_rows.push_back(dir_row(pps_pkg::REQ_ARRIVAL, 16'hFFFF, 16'h0002, 8'hFF,
                                    1'b1, pps_pkg::EV_ACCEPT, 16'hFFFF, 16'h0002, 32'd0, 32'd3));
    directed_rows.push_back(dir_row(pps_pkg::REQ_TICK, 16'h0000, 16'h0000, 8'h00,
                                    1'b0, pps_pkg::EV_ACCEPT, '0, '0, '0, '0));
    // Zero work is kept as one tick of work; same priority queues behind the earlier job.
    directed_rows.push_back(dir_row(pps_pkg::REQ_ARRIVAL, 16'h0011, 16'h0000, 8'h10,
                                    1'b1, pps_pkg::EV_ACCEPT, 16'h0011, 16'h0001, 32'd0, 32'd4));
    directed_rows.push_back(dir_row(pps_pkg::REQ_ARRIVAL, 16'h5AA5, 16'h00A5, 8'h80,
                                    1'b0, pps_pkg::EV_ACCEPT, '0, '0, '0, '0));
    for (int k = 0; k < 12; k++)
      directed_rows.push_back(dir_row(pps_pkg::REQ_ARRIVAL, 16'(16'h0100 + k),
                                      16'(16'd1 + k), 8'(k * 21),
                                      1'b0, pps_pkg::EV_ACCEPT, '0, '0, '0, '0));
    // The table is full now, so both extremes of the arrival fields are turned away.
    directed_rows.push_back(dir_row(pps_pkg::REQ_ARRIVAL, 16'hFFFF, 16'hFFFF, 8'hFF,
                                    1'b1, pps_pkg::EV_FULL, 16'hFFFF, 16'h0000, 32'd0, 32'd4));
    directed_rows.push_back(dir_row(pps_pkg::REQ_ARRIVAL, 16'h0000, 16'h0000, 8'h00,
                                    1'b1, pps_pkg::EV_FULL, 16'h0000, 16'h0000, 32'd0, 32'd4));
    directed_rows.push_back(dir_row(pps_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF, 8'hFF,
                                    1'b0, pps_pkg::EV_ACCEPT, '0, '0, '0, '0));
    directed_rows.push_back(dir_row(pps_pkg::REQ_ARRIVAL, 16'hA55A, 16'h5A5A, 8'h5A,
                                    1'b0, pps_pkg::EV_ACCEPT, '0, '0, '0, '0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    seg_left    = 0;
    arrival_pct = 50;
    repeat (1050) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        case ($urandom_range(0, 2))
          0: arrival_pct = 35;
          1: arrival_pct = 50;
          default: arrival_pct = 65;
        endcase
      end
      seg_left--;
      t = random_item(arrival_pct);
      send_item(t, 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/pps_pkg.sv
sv/pps_cell.sv
sv/preemptive_priority_scheduler.sv
sv/pps_checker.sv
bench/testbench.sv
